[rtl/stk5fr_pkg.sv]
package stk5fr_pkg;

  // Payload buffer size and the widths that follow from it.
  localparam int MAX_PAYLOAD = 512;
  localparam int BUF_AW      = $clog2(MAX_PAYLOAD);
  localparam int CNT_W       = $clog2(MAX_PAYLOAD + 1);

  // Fixed field widths of the channels.
  localparam int BYTE_W      = 8;
  localparam int LEN_W       = 16;
  localparam int PIDX_W      = 9;
  localparam int STATUS_W    = 3;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 8;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_START = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_TOKEN = 1'b1;

  // Configuration reset values.
  localparam logic [BYTE_W-1:0] START_RESET = 8'd27;
  localparam logic [BYTE_W-1:0] TOKEN_RESET = 8'd14;

  typedef enum logic [2:0] {
    PH_HUNT,
    PH_SEQ,
    PH_LEN_HI,
    PH_LEN_LO,
    PH_TOKEN,
    PH_DATA,
    PH_CHECK
  } phase_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_PROGRESS,
    ST_PAYLOAD,
    ST_OK,
    ST_BADSUM,
    ST_BADTOKEN,
    ST_TIMEOUT,
    ST_TOOLONG
  } status_t;

  typedef struct packed {
    logic [BYTE_W-1:0] start_byte;
    logic [BYTE_W-1:0] token_byte;
  } cfg_t;

  typedef struct packed {
    status_t             status;
    logic [BYTE_W-1:0]   payload_byte;
    logic [PIDX_W-1:0]   payload_index;
    logic [BYTE_W-1:0]   sequence_number;
    logic [LEN_W-1:0]    message_length;
  } result_t;

endpackage

[rtl/stk5fr_if.sv]
interface stk5fr_rx_if;
  logic                             valid;
  logic                             ready;
  logic [stk5fr_pkg::BYTE_W-1:0]    rx_byte;
  logic                             timed_out;

  modport source (output valid, output rx_byte, output timed_out, input ready);
  modport sink (input valid, input rx_byte, input timed_out, output ready);
endinterface

interface stk5fr_res_if;
  logic                             valid;
  logic                             ready;
  logic [stk5fr_pkg::STATUS_W-1:0]  status;
  logic [stk5fr_pkg::BYTE_W-1:0]    payload_byte;
  logic [stk5fr_pkg::PIDX_W-1:0]    payload_index;
  logic [stk5fr_pkg::BYTE_W-1:0]    sequence_number;
  logic [stk5fr_pkg::LEN_W-1:0]     message_length;

  modport source (
    output valid, output status, output payload_byte, output payload_index,
    output sequence_number, output message_length, input ready
  );
  modport sink (
    input valid, input status, input payload_byte, input payload_index,
    input sequence_number, input message_length, output ready
  );
endinterface

[rtl/stk5fr_parser.sv]
module stk5fr_parser (
  input  logic                          clk,
  input  logic                          rst,
  input  stk5fr_pkg::cfg_t              cfg,
  input  logic                          step,
  input  logic [stk5fr_pkg::BYTE_W-1:0] rx_byte,
  input  logic                          timed_out,
  output stk5fr_pkg::result_t           result
);
  import stk5fr_pkg::*;

  phase_t              phase, phase_next;
  logic [BYTE_W-1:0]   xor_acc, xor_acc_next;
  logic [BYTE_W-1:0]   seq, seq_next;
  logic [LEN_W-1:0]    length, length_next;
  logic [CNT_W-1:0]    count, count_next;

  logic [LEN_W-1:0]    len_full;
  logic                too_long;
  logic [CNT_W-1:0]    count_inc;
  logic                data_done;
  logic                start_hit;
  logic                token_hit;

  status_t             status;
  logic [BYTE_W-1:0]   pbyte;
  logic [PIDX_W-1:0]   pindex;

  logic                buf_we;
  logic [BYTE_W-1:0]   payload_store [MAX_PAYLOAD];

  assign len_full  = {length[LEN_W-1:BYTE_W], rx_byte};
  assign too_long  = len_full > LEN_W'(MAX_PAYLOAD);
  assign count_inc = count + CNT_W'(1);
  assign data_done = LEN_W'(count_inc) >= length;
  assign start_hit = rx_byte == cfg.start_byte;
  assign token_hit = rx_byte == cfg.token_byte;

  // Next phase.
  always_comb begin
    phase_next = phase;
    if (timed_out) begin
      phase_next = PH_HUNT;
    end else begin
      unique case (phase)
        PH_HUNT:   phase_next = start_hit ? PH_SEQ : PH_HUNT;
        PH_SEQ:    phase_next = PH_LEN_HI;
        PH_LEN_HI: phase_next = PH_LEN_LO;
        PH_LEN_LO: phase_next = too_long ? PH_HUNT : PH_TOKEN;
        PH_TOKEN: begin
          if (!token_hit) begin
            phase_next = PH_HUNT;
          end else if (length == '0) begin
            phase_next = PH_CHECK;
          end else begin
            phase_next = PH_DATA;
          end
        end
        PH_DATA:   phase_next = data_done ? PH_CHECK : PH_DATA;
        PH_CHECK:  phase_next = PH_HUNT;
        default:   phase_next = PH_HUNT;
      endcase
    end
  end

  // Header fields, running checksum and byte count.
  always_comb begin
    xor_acc_next = xor_acc;
    seq_next     = seq;
    length_next  = length;
    count_next   = count;
    if (!timed_out) begin
      xor_acc_next = xor_acc ^ rx_byte;
      unique case (phase)
        PH_HUNT:   if (start_hit) xor_acc_next = rx_byte;
        PH_SEQ:    seq_next = rx_byte;
        PH_LEN_HI: length_next = {rx_byte, BYTE_W'(0)};
        PH_LEN_LO: length_next = len_full;
        PH_TOKEN:  if (token_hit) count_next = '0;
        PH_DATA:   count_next = count_inc;
        default:   ;
      endcase
    end
  end

  // Result of this byte.
  always_comb begin
    status = ST_PROGRESS;
    pbyte  = '0;
    pindex = '0;
    if (timed_out) begin
      status = ST_TIMEOUT;
    end else begin
      unique case (phase)
        PH_LEN_LO: if (too_long) status = ST_TOOLONG;
        PH_TOKEN:  if (!token_hit) status = ST_BADTOKEN;
        PH_DATA: begin
          status = ST_PAYLOAD;
          pbyte  = rx_byte;
          pindex = PIDX_W'(count);
        end
        PH_CHECK:  status = (xor_acc_next == '0) ? ST_OK : ST_BADSUM;
        default:   ;
      endcase
    end
  end

  assign result = '{
    status:          status,
    payload_byte:    pbyte,
    payload_index:   pindex,
    sequence_number: seq_next,
    message_length:  length_next
  };

  always_ff @(posedge clk) begin
    if (rst) begin
      phase   <= PH_HUNT;
      xor_acc <= '0;
      seq     <= '0;
      length  <= '0;
      count   <= '0;
    end else if (step) begin
      phase   <= phase_next;
      xor_acc <= xor_acc_next;
      seq     <= seq_next;
      length  <= length_next;
      count   <= count_next;
    end
  end

  // The count stays below the buffer size while data is being taken.
  assign buf_we = step && !timed_out && (phase == PH_DATA);

  always_ff @(posedge clk) begin
    if (buf_we) begin
      payload_store[count[BUF_AW-1:0]] <= rx_byte;
    end
  end

endmodule

[rtl/stk5fr_out_reg.sv]
module stk5fr_out_reg (
  input  logic                clk,
  input  logic                rst,
  input  logic                load,
  input  stk5fr_pkg::result_t din,
  output logic                can_load,
  output logic                valid,
  input  logic                ready,
  output stk5fr_pkg::result_t dout
);
  import stk5fr_pkg::*;

  assign can_load = !valid || ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= 1'b1;
    end else if (ready) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      dout <= din;
    end
  end

endmodule

[rtl/stk5500v2_placeholder_do_not_use.sv]
module stk5fr_cfg_regs (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                we,
  input  logic [stk5fr_pkg::CFG_IDX_W-1:0]    index,
  input  logic [stk5fr_pkg::CFG_DATA_W-1:0]   data,
  output stk5fr_pkg::cfg_t                    cfg
);
  import stk5fr_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.start_byte <= START_RESET;
      cfg.token_byte <= TOKEN_RESET;
    end else if (we) begin
      unique case (index)
        CFG_START: cfg.start_byte <= data;
        CFG_TOKEN: cfg.token_byte <= data;
        default:   ;
      endcase
    end
  end

endmodule

[rtl/stk500v2_frame_receiver_top.sv]
// STK500v2 frame receiver. Each beat on the rx channel carries one byte from
// the serial line and a timeout flag, and produces exactly one beat on the res
// channel. That beat gives the parse status, the payload byte and its buffer
// position when a payload byte was taken, and the sequence number and
// announced length of the current frame. A frame is the start byte, a
// sequence number, a big-endian 16-bit length, the token byte, the payload
// and an XOR checksum; the XOR over the whole frame must come to zero. A
// timeout aborts any frame in progress and is reported even while hunting.
// Lengths above 512 bytes are rejected with the too-long status as soon as
// the low length byte arrives. For each byte taken, the parser state is
// updated and the result lands in the output register at the same edge, so
// a new byte is taken every cycle while the consumer keeps up. Throughput is
// set by that output register alone; when it holds a beat that has not been
// taken, the rx channel is held off. Payload bytes are written into a
// 512-byte buffer memory, one write per cycle while bytes are taken. Start
// and token byte values are set through the configuration port (index 0 and
// 1) and apply from the next byte; write them only while the block is idle.
module stk500v2_frame_receiver_top (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [stk5fr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [stk5fr_pkg::CFG_DATA_W-1:0] cfg_data,
  stk5fr_rx_if.sink                         rx,
  stk5fr_res_if.source                      res
);
  import stk5fr_pkg::*;

  cfg_t    cfg;
  result_t result;
  result_t held;
  logic    can_load;
  logic    step;

  stk5fr_cfg_regs u_cfg (
    .clk   (clk),
    .rst   (rst),
    .we    (cfg_we),
    .index (cfg_index),
    .data  (cfg_data),
    .cfg   (cfg)
  );

  // A byte is taken whenever the output register is free or being emptied.
  assign rx.ready = !rst && can_load;
  assign step     = rx.valid && rx.ready;

  stk5fr_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .step      (step),
    .rx_byte   (rx.rx_byte),
    .timed_out (rx.timed_out),
    .result    (result)
  );

  stk5fr_out_reg u_out (
    .clk      (clk),
    .rst      (rst),
    .load     (step),
    .din      (result),
    .can_load (can_load),
    .valid    (res.valid),
    .ready    (res.ready),
    .dout     (held)
  );

  assign res.status          = held.status;
  assign res.payload_byte    = held.payload_byte;
  assign res.payload_index   = held.payload_index;
  assign res.sequence_number = held.sequence_number;
  assign res.message_length  = held.message_length;

endmodule

[rtl/stk5fr_checker.sv]
module stk5fr_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              rx_valid,
  input logic                              rx_ready,
  input logic                              rx_timed_out,
  input logic                              res_valid,
  input logic                              res_ready,
  input logic [stk5fr_pkg::STATUS_W-1:0]   res_status,
  input logic [stk5fr_pkg::BYTE_W-1:0]     res_payload_byte,
  input logic [stk5fr_pkg::PIDX_W-1:0]     res_payload_index
);
  import stk5fr_pkg::*;

  // A timed-out byte shows up as a timeout beat on the very next cycle.
  a_timeout_next: assert property (@(posedge clk) disable iff (rst)
    !rst && rx_valid && rx_ready && rx_timed_out
      |=> res_valid && (res_status == ST_TIMEOUT))
    else $error("timeout byte not reported next cycle");

  // Payload fields read zero unless a payload byte is reported.
  a_payload_zero: assert property (@(posedge clk) disable iff (rst)
    res_valid && (res_status != ST_PAYLOAD)
      |-> (res_payload_byte == '0) && (res_payload_index == '0))
    else $error("payload fields set on a non-payload beat");

  // Input is taken exactly when the output register can accept a beat.
  a_ready_follows: assert property (@(posedge clk) disable iff (rst)
    rx_ready == (!res_valid || res_ready))
    else $error("rx ready does not follow output occupancy");

  // A stalled result beat holds its status.
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(res_status))
    else $error("stalled result beat changed");

endmodule

bind stk500v2_frame_receiver_top stk5fr_checker u_checker (
  .clk               (clk),
  .rst               (rst),
  .rx_valid          (rx.valid),
  .rx_ready          (rx.ready),
  .rx_timed_out      (rx.timed_out),
  .res_valid         (res.valid),
  .res_ready         (res.ready),
  .res_status        (res.status),
  .res_payload_byte  (res.payload_byte),
  .res_payload_index (res.payload_index)
);
